// File: hdl/lbs_pkg.sv
// shared types, constants and the half width table of the lane border search
package lbs_pkg;

    localparam int COLS_DEFAULT = 128;
    localparam int ROWS_DEFAULT = 64;
    localparam int POS_W        = 8;
    localparam int MODE_W       = 3;
    localparam int QUEUE_DEPTH  = 4;
    localparam int ROM_DEPTH    = 64;

    localparam logic [MODE_W-1:0] MODE_TRACK   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SIXTH   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_QUARTER = 3'd3;
    localparam logic [MODE_W-1:0] MODE_THIRD   = 3'd4;

    // one finished row handed from the scanner to the center stage
    typedef struct packed {
        logic [POS_W-1:0] row;
        logic             left_hit;
        logic [POS_W-1:0] left_pos;
        logic             right_hit;
        logic [POS_W-1:0] right_pos;
        logic             fallback;
        logic             restart;
    } t_row_rec;

    localparam logic [2:0] HALF_WIDTH_ROM [ROM_DEPTH] = '{
        3'd1, 3'd1, 3'd1, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2,
        3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2,
        3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd3,
        3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3,
        3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
        3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4,
        3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0
    };

endpackage

// File: hdl/lane_border_search_core.sv
// top level of the lane border search: scanner, row queue and center stage
//
// Binary pixels enter on the input channel (i_in_valid / o_in_stall), one word a
// clock, bottom row first and left to right; i_frame_start marks the first pixel
// of a frame and i_row_end the last pixel of each row. A word is taken at any
// edge where valid is high and stall is low, so while stall is low the sustained
// rate is one pixel per cycle. Every row except row 0 yields, in a valid search
// mode, one result word on the output channel (o_out_valid / i_out_stall): row
// number, both border columns with hit flags and the lane center. The result is
// registered in the row queue, then in the center stage's output register.
// The scanner finishes a row in the cycle of its last pixel and drops a record in
// a four-entry queue; the center stage drains it independently. When the receiver
// stalls, the output word holds, records pile up in the queue and o_in_stall rises
// only once the queue is full. The search mode register is written through
// i_cfg_valid / o_cfg_ready (always ready); the user must write it only while the
// block is idle, which the block itself does not enforce. Reset loads mode 1,
// clears the queue and output, and sets the frame state as a frame start does.
module lane_border_search_core #(
    parameter int COLS = lbs_pkg::COLS_DEFAULT,
    parameter int ROWS = lbs_pkg::ROWS_DEFAULT
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [lbs_pkg::MODE_W-1:0] i_cfg_search_mode,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_pixel_white,
    input  logic                       i_frame_start,
    input  logic                       i_row_end,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [5:0]                 o_row_number,
    output logic [6:0]                 o_left_column,
    output logic [6:0]                 o_right_column,
    output logic [6:0]                 o_center_column,
    output logic                       o_left_hit,
    output logic                       o_right_hit
);

    logic              push, pop, queue_full, head_valid;
    lbs_pkg::t_row_rec push_rec, head_rec;

    lbs_front #(
        .COLS(COLS),
        .ROWS(ROWS)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_search_mode (i_cfg_search_mode),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_pixel_white     (i_pixel_white),
        .i_frame_start     (i_frame_start),
        .i_row_end         (i_row_end),
        .i_queue_full      (queue_full),
        .o_push            (push),
        .o_push_rec        (push_rec)
    );

    lbs_queue #(
        .DEPTH(lbs_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_rec (push_rec),
        .i_pop      (pop),
        .o_full     (queue_full),
        .o_valid    (head_valid),
        .o_head     (head_rec)
    );

    lbs_back #(
        .COLS(COLS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_rec_valid     (head_valid),
        .i_rec           (head_rec),
        .o_pop           (pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_row_number    (o_row_number),
        .o_left_column   (o_left_column),
        .o_right_column  (o_right_column),
        .o_center_column (o_center_column),
        .o_left_hit      (o_left_hit),
        .o_right_hit     (o_right_hit)
    );

endmodule

// File: hdl/lbs_front.sv
// pixel scanner: counts rows/columns, finds borders, pushes a record per row > 0
module lbs_front #(
    parameter int COLS = lbs_pkg::COLS_DEFAULT,
    parameter int ROWS = lbs_pkg::ROWS_DEFAULT
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [lbs_pkg::MODE_W-1:0] i_cfg_search_mode,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_pixel_white,
    input  logic                       i_frame_start,
    input  logic                       i_row_end,
    input  logic                       i_queue_full,
    output logic                       o_push,
    output lbs_pkg::t_row_rec          o_push_rec
);

    localparam int PW = lbs_pkg::POS_W;
    localparam logic [PW-1:0] COLS_LAST = PW'(COLS - 1);
    localparam logic [PW-1:0] COLS_HALF = PW'(COLS / 2);
    localparam logic [PW-1:0] COLS_8TH  = PW'(COLS / 8);
    localparam logic [PW-1:0] COLS_6TH  = PW'(COLS / 6);
    localparam logic [PW-1:0] COLS_4TH  = PW'(COLS / 4);
    localparam logic [PW-1:0] COLS_3RD  = PW'(COLS / 3);
    localparam logic [PW-1:0] ROWS_LAST = PW'(ROWS - 1);
    localparam logic [PW-1:0] COL_MAX   = {PW{1'b1}};

    logic [lbs_pkg::MODE_W-1:0] r_mode;
    logic [PW-1:0] r_tracked, n_tracked;
    logic [PW-1:0] r_row, n_row;
    logic [PW-1:0] r_col, n_col;
    logic [1:0]    r_recent, n_recent;
    logic          r_lseen, n_lseen;
    logic [PW-1:0] r_lpos, n_lpos;
    logic          r_rseen, n_rseen;
    logic [PW-1:0] r_rpos, n_rpos;
    logic          r_restart, n_restart;

    logic          accept;
    logic          valid_mode;
    logic [PW-1:0] e_tracked, e_row, e_col, e_lpos, e_rpos;
    logic [1:0]    e_recent;
    logic          e_lseen, e_rseen, e_restart;
    logic [PW-1:0] start;
    logic [PW:0]   rlimit_sum;
    logic [PW-1:0] rlimit;
    logic [PW-1:0] col_m2;
    logic          left_match, right_match;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = i_queue_full;
    assign accept      = i_in_valid && !o_in_stall;
    assign valid_mode  = r_mode inside {[lbs_pkg::MODE_TRACK:lbs_pkg::MODE_THIRD]};

    // frame start takes effect before the pixel is used
    always_comb begin
        e_tracked = i_frame_start ? COLS_HALF : r_tracked;
        e_row     = i_frame_start ? ROWS_LAST : r_row;
        e_col     = i_frame_start ? '0 : r_col;
        e_recent  = i_frame_start ? 2'b00 : r_recent;
        e_lseen   = i_frame_start ? 1'b0 : r_lseen;
        e_lpos    = i_frame_start ? '0 : r_lpos;
        e_rseen   = i_frame_start ? 1'b0 : r_rseen;
        e_rpos    = i_frame_start ? '0 : r_rpos;
        e_restart = i_frame_start | r_restart;
    end

    always_comb begin
        case (r_mode)
            lbs_pkg::MODE_SIXTH:   start = COLS_6TH;
            lbs_pkg::MODE_QUARTER: start = COLS_4TH;
            lbs_pkg::MODE_THIRD:   start = COLS_3RD;
            default: begin
                if (e_row == ROWS_LAST) begin
                    start = '0;
                end else if (e_tracked > COLS_8TH) begin
                    start = e_tracked - COLS_8TH;
                end else begin
                    start = '0;
                end
            end
        endcase
    end

    always_comb begin
        rlimit_sum  = {1'b0, e_lpos} + {1'b0, COLS_6TH};
        rlimit      = (rlimit_sum > {1'b0, COLS_LAST}) ? COLS_LAST : rlimit_sum[PW-1:0];
        col_m2      = e_col - PW'(2);
        // black after two whites, inside the window right of the left border
        right_match = valid_mode && e_lseen && !i_pixel_white && (e_recent == 2'b11)
                      && (e_col > e_lpos) && (e_col <= rlimit);
        // black then two whites, start column counts back two
        left_match  = valid_mode && !e_lseen && i_pixel_white && (e_recent == 2'b01)
                      && (e_col >= PW'(2)) && (e_col < COLS_LAST) && (col_m2 >= start);
    end

    always_comb begin
        n_tracked = left_match ? col_m2 : e_tracked;
        n_lseen   = e_lseen | left_match;
        n_lpos    = left_match ? col_m2 : e_lpos;
        n_rseen   = e_rseen | right_match;
        n_rpos    = right_match ? e_col : e_rpos;
        n_recent  = {e_recent[0], i_pixel_white};
        n_row     = e_row;
        n_col     = e_col;
        n_restart = e_restart;

        o_push               = 1'b0;
        o_push_rec.row       = e_row;
        o_push_rec.left_hit  = n_lseen;
        o_push_rec.left_pos  = n_lpos;
        o_push_rec.right_hit = n_rseen;
        o_push_rec.right_pos = n_rpos;
        o_push_rec.fallback  = (r_mode == lbs_pkg::MODE_TRACK);
        o_push_rec.restart   = e_restart;

        if (i_row_end) begin
            if (valid_mode && (e_row != '0)) begin
                o_push    = accept;
                n_restart = 1'b0;
            end
            if (e_row != '0) begin
                n_row = e_row - PW'(1);
            end
            n_col    = '0;
            n_recent = 2'b00;
            n_lseen  = 1'b0;
            n_lpos   = '0;
            n_rseen  = 1'b0;
            n_rpos   = '0;
        end else if (e_col != COL_MAX) begin
            n_col = e_col + PW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= lbs_pkg::MODE_TRACK;
            r_tracked <= COLS_HALF;
            r_row     <= ROWS_LAST;
            r_col     <= '0;
            r_recent  <= 2'b00;
            r_lseen   <= 1'b0;
            r_lpos    <= '0;
            r_rseen   <= 1'b0;
            r_rpos    <= '0;
            r_restart <= 1'b1;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_mode <= i_cfg_search_mode;
            end
            if (accept) begin
                r_tracked <= n_tracked;
                r_row     <= n_row;
                r_col     <= n_col;
                r_recent  <= n_recent;
                r_lseen   <= n_lseen;
                r_lpos    <= n_lpos;
                r_rseen   <= n_rseen;
                r_rpos    <= n_rpos;
                r_restart <= n_restart;
            end
        end
    end

endmodule

// File: hdl/lbs_queue.sv
// short first-in first-out queue of row records between scanner and center stage
module lbs_queue #(
    parameter int DEPTH = lbs_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  lbs_pkg::t_row_rec i_push_rec,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_valid,
    output lbs_pkg::t_row_rec o_head
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    lbs_pkg::t_row_rec r_slot [DEPTH];
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
        end
        case ({do_push, do_pop})
            2'b10:   n_count = r_count + CW'(1);
            2'b01:   n_count = r_count - CW'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_push_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// File: hdl/lbs_back.sv
// center stage: works out the lane center of each row record and holds the result word
module lbs_back #(
    parameter int COLS = lbs_pkg::COLS_DEFAULT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rec_valid,
    input  lbs_pkg::t_row_rec i_rec,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [5:0]        o_row_number,
    output logic [6:0]        o_left_column,
    output logic [6:0]        o_right_column,
    output logic [6:0]        o_center_column,
    output logic              o_left_hit,
    output logic              o_right_hit
);

    localparam int PW = lbs_pkg::POS_W;
    localparam logic [PW-1:0] COLS_LAST = PW'(COLS - 1);
    localparam logic [PW-1:0] COLS_HALF = PW'(COLS / 2);
    localparam logic [PW-1:0] ROM_LAST  = PW'(lbs_pkg::ROM_DEPTH - 1);

    logic          r_valid, n_valid;
    logic [PW-1:0] r_prev_center;
    logic [5:0]    r_row;
    logic [6:0]    r_left, r_right, r_center;
    logic          r_lhit, r_rhit;

    logic [PW-1:0] prev;
    logic [2:0]    half;
    logic [PW:0]   sum_lr, sum_lh, center_wide;
    logic [PW-1:0] center;

    assign o_pop = i_rec_valid && (!r_valid || !i_out_stall);

    always_comb begin
        prev   = i_rec.restart ? COLS_HALF : r_prev_center;
        half   = (i_rec.row <= ROM_LAST) ? lbs_pkg::HALF_WIDTH_ROM[i_rec.row[5:0]] : 3'd0;
        sum_lr = {1'b0, i_rec.left_pos} + {1'b0, i_rec.right_pos};
        sum_lh = {1'b0, i_rec.left_pos} + (PW + 1)'(half);
        if (i_rec.left_hit && i_rec.right_hit) begin
            center_wide = {1'b0, sum_lr[PW:1]};
        end else if (i_rec.left_hit && i_rec.fallback) begin
            center_wide = sum_lh;
        end else begin
            center_wide = {1'b0, prev};
        end
        center = (center_wide > {1'b0, COLS_LAST}) ? COLS_LAST : center_wide[PW-1:0];
    end

    always_comb begin
        if (o_pop) begin
            n_valid = 1'b1;
        end else if (i_out_stall) begin
            n_valid = r_valid;
        end else begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_row    <= i_rec.row[5:0];
            r_left   <= i_rec.left_hit ? i_rec.left_pos[6:0] : 7'd0;
            r_right  <= i_rec.right_hit ? i_rec.right_pos[6:0] : 7'd0;
            r_center <= center[6:0];
            r_lhit   <= i_rec.left_hit;
            r_rhit   <= i_rec.right_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid       <= 1'b0;
            r_prev_center <= COLS_HALF;
        end else begin
            r_valid <= n_valid;
            if (o_pop) begin
                r_prev_center <= center;
            end
        end
    end

    assign o_out_valid     = r_valid;
    assign o_row_number    = r_row;
    assign o_left_column   = r_left;
    assign o_right_column  = r_right;
    assign o_center_column = r_center;
    assign o_left_hit      = r_lhit;
    assign o_right_hit     = r_rhit;

endmodule
